### rtl/pif_pkg.sv
// ============================================================================
// pif_pkg: shared types and constants for the integer formatter
// Codes, digit character function and the handoff between digit extractor and emitter.
// ============================================================================
`default_nettype none
package pif_pkg;
    localparam int MAX_CHARS  = 64;
    localparam int NDIG_MAX   = 22;
    localparam int BCD_DIGITS = 20;

    localparam logic [2:0] ACT_SDEC = 3'd0;
    localparam logic [2:0] ACT_UDEC = 3'd1;
    localparam logic [2:0] ACT_OCT  = 3'd2;
    localparam logic [2:0] ACT_HEXL = 3'd3;
    localparam logic [2:0] ACT_HEXU = 3'd4;

    localparam logic [1:0] LEN_32 = 2'd0;
    localparam logic [1:0] LEN_16 = 2'd1;
    localparam logic [1:0] LEN_64 = 2'd2;

    localparam logic [1:0] BASE_DEC = 2'd0;
    localparam logic [1:0] BASE_OCT = 2'd1;
    localparam logic [1:0] BASE_HEX = 2'd2;

    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_XL    = 8'd120;
    localparam logic [7:0] CH_XU    = 8'd88;

    typedef enum logic [2:0] {
        S_IDLE, S_DIGITS, S_PAD, S_PRE, S_ZPAD, S_NZ, S_BODY, S_TAIL
    } t_state;

    typedef struct packed {
        logic       done;
        logic [4:0] ndig;
    } t_dig_status;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        begin
            if (d < 4'd10) c = CH_ZERO + {4'd0, d};
            else c = (upper ? 8'd55 : 8'd87) + {4'd0, d};
            return c;
        end
    endfunction
endpackage
`default_nettype wire

### rtl/pif_digits.sv
// ============================================================================
// pif_digits: iterative digit extractor
// Decimal runs 64 shift-and-add-3 steps into a BCD register first; digits
// are then shifted out one per cycle for every base, stored LSD first.
// ============================================================================
`default_nettype none
module pif_digits (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_load,
    input  wire logic [63:0]               i_mag,
    input  wire logic [1:0]                i_base_sel,
    input  wire logic [4:0]                i_rd_idx,
    output logic [3:0]                     o_rd_digit,
    output pif_pkg::t_dig_status           o_status
);
    logic [63:0] r_bin, n_bin;
    logic [79:0] r_bcd, n_bcd;
    logic [79:0] adj;
    logic [5:0]  r_bit, n_bit;
    logic        r_conv, n_conv;
    logic        r_busy, n_busy;
    logic [4:0]  r_ndig, n_ndig;
    logic [1:0]  r_base;
    logic [3:0]  r_dig [pif_pkg::NDIG_MAX];
    logic [3:0]  dval;
    logic        dwe;

    always_comb begin
        for (int k = 0; k < pif_pkg::BCD_DIGITS; k++) begin
            adj[4*k +: 4] = (r_bcd[4*k +: 4] >= 4'd5) ? r_bcd[4*k +: 4] + 4'd3
                                                       : r_bcd[4*k +: 4];
        end
    end

    always_comb begin
        n_bin  = r_bin;
        n_bcd  = r_bcd;
        n_bit  = r_bit;
        n_conv = r_conv;
        n_busy = r_busy;
        n_ndig = r_ndig;
        dwe    = 1'b0;
        dval   = 4'd0;
        if (i_load) begin
            n_bin  = i_mag;
            n_bcd  = (i_base_sel == pif_pkg::BASE_DEC) ? 80'd0 : {16'd0, i_mag};
            n_bit  = 6'd0;
            n_conv = i_base_sel == pif_pkg::BASE_DEC;
            n_busy = 1'b1;
            n_ndig = 5'd0;
        end else if (r_busy) begin
            if (r_conv) begin
                n_bcd = {adj[78:0], r_bin[63]};
                n_bin = {r_bin[62:0], 1'b0};
                n_bit = r_bit + 6'd1;
                if (r_bit == 6'd63) n_conv = 1'b0;
            end else if (r_bcd == 80'd0) begin
                n_busy = 1'b0;
            end else if (r_base == pif_pkg::BASE_OCT) begin
                dwe = 1'b1; dval = {1'b0, r_bcd[2:0]};
                n_bcd = r_bcd >> 3;
                n_ndig = r_ndig + 5'd1;
            end else begin
                dwe = 1'b1; dval = r_bcd[3:0];
                n_bcd = r_bcd >> 4;
                n_ndig = r_ndig + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_bit  <= n_bit;
        r_conv <= n_conv;
        r_ndig <= n_ndig;
        if (i_load) r_base <= i_base_sel;
        if (dwe) r_dig[r_ndig] <= dval;
    end

    assign o_rd_digit       = (i_rd_idx < 5'(pif_pkg::NDIG_MAX)) ? r_dig[i_rd_idx] : 4'd0;
    assign o_status.done    = !r_busy && !i_load;
    assign o_status.ndig    = r_ndig;
endmodule
`default_nettype wire

### rtl/printf_integer_formatter_top.sv
// ============================================================================
// printf_integer_formatter_top: printf style d/u/o/x/X integer conversion
// Digit phase: decimal first runs 64 shift-and-add-3 steps; digits are then
// shifted out for every base. Six phases then follow (pad, prefix, zero pad,
// precision zeros, body, tail), one character per cycle; each character is
// held, then strobed when the next is made or the run ends. One transaction at
// a time; busy drops as the last character is strobed; receiver cannot stall.
// Reset is synchronous, active low, and returns the sequencer to idle.
// ============================================================================
`default_nettype none
module printf_integer_formatter_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_action,
    input  wire logic [1:0]  i_length_class,
    input  wire logic [63:0] i_value,
    input  wire logic [5:0]  i_precision,
    input  wire logic [6:0]  i_width,
    input  wire logic [4:0]  i_flags,
    output logic             o_strobe,
    output logic [7:0]       o_character,
    output logic             o_last,
    output logic             o_empty_res
);
    pif_pkg::t_state r_state, n_state;
    pif_pkg::t_dig_status st;
    logic [5:0]  r_prec;
    logic [6:0]  r_wid;
    logic        r_left, r_zpad, r_upper;
    logic [1:0]  r_plen;
    logic [7:0]  r_pre0, r_pre1;
    logic        r_sgn, r_hex;
    logic [6:0]  r_cnt, n_cnt;
    logic [6:0]  r_out, n_out;
    logic [6:0]  r_nz, r_pad;
    logic [7:0]  r_sign_ch;
    logic        r_alt_oct;
    logic [3:0]  rd_digit;
    logic        accept, emit;
    logic [7:0]  ch;
    logic [63:0] masked, mag;
    logic        neg, is_signed;
    logic [2:0]  act;
    logic [1:0]  base_sel;
    logic [6:0]  nz_c, body_c;
    logic [4:0]  rd_idx;

    assign accept = start && !busy;
    assign busy   = r_state != pif_pkg::S_IDLE;

    always_comb begin
        act = (i_action > pif_pkg::ACT_HEXU) ? pif_pkg::ACT_SDEC : i_action;
        is_signed = act == pif_pkg::ACT_SDEC;
        if (i_length_class == pif_pkg::LEN_16) masked = {48'd0, i_value[15:0]};
        else if (i_length_class == pif_pkg::LEN_64) masked = i_value;
        else masked = {32'd0, i_value[31:0]};
        if (i_length_class == pif_pkg::LEN_16) neg = i_value[15];
        else if (i_length_class == pif_pkg::LEN_64) neg = i_value[63];
        else neg = i_value[31];
        neg = neg && is_signed;
        mag = masked;
        if (neg) begin
            if (i_length_class == pif_pkg::LEN_16) mag = {48'd0, 16'(~i_value[15:0] + 16'd1)};
            else if (i_length_class == pif_pkg::LEN_64) mag = ~i_value + 64'd1;
            else mag = {32'd0, 32'(~i_value[31:0] + 32'd1)};
        end
        if (act == pif_pkg::ACT_OCT) base_sel = pif_pkg::BASE_OCT;
        else if (act == pif_pkg::ACT_HEXL || act == pif_pkg::ACT_HEXU)
            base_sel = pif_pkg::BASE_HEX;
        else base_sel = pif_pkg::BASE_DEC;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prec  <= i_precision;
            r_wid   <= i_width;
            r_left  <= i_flags[0];
            r_zpad  <= i_flags[4];
            r_upper <= act == pif_pkg::ACT_HEXU;
            r_sgn   <= is_signed && (neg || i_flags[1] || i_flags[2]);
            r_sign_ch <= neg ? pif_pkg::CH_MINUS :
                         (i_flags[1] ? pif_pkg::CH_PLUS : pif_pkg::CH_SPACE);
            r_hex   <= i_flags[3] && base_sel == pif_pkg::BASE_HEX && mag != 64'd0;
            r_alt_oct <= i_flags[3] && base_sel == pif_pkg::BASE_OCT;
        end
    end

    always_comb begin
        nz_c = ({1'b0, r_prec} > {2'd0, st.ndig}) ? 7'({1'b0, r_prec} - {2'd0, st.ndig}) : 7'd0;
        if (r_alt_oct && nz_c == 7'd0) nz_c = 7'd1;
        body_c = nz_c + {2'd0, st.ndig} + {6'd0, r_sgn} + (r_hex ? 7'd2 : 7'd0);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == pif_pkg::S_DIGITS && st.done) begin
            r_nz  <= nz_c;
            r_pad <= (r_wid > body_c) ? 7'(r_wid - body_c) : 7'd0;
            r_pre0 <= r_sgn ? r_sign_ch : pif_pkg::CH_ZERO;
            r_pre1 <= r_sgn ? pif_pkg::CH_ZERO : (r_upper ? pif_pkg::CH_XU : pif_pkg::CH_XL);
            r_plen <= 2'({1'b0, r_sgn} + (r_hex ? 2'd2 : 2'd0));
        end
    end

    assign rd_idx = r_cnt[4:0] - 5'd1;

    pif_digits u_digits (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_mag      (mag),
        .i_base_sel (base_sel),
        .i_rd_idx   (rd_idx),
        .o_rd_digit (rd_digit),
        .o_status   (st)
    );

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            pif_pkg::S_IDLE: if (accept) n_state = pif_pkg::S_DIGITS;
            pif_pkg::S_DIGITS: if (st.done) begin
                n_state = pif_pkg::S_PAD;
                n_cnt   = (r_left || r_zpad) ? 7'd0 :
                          ((r_wid > body_c) ? 7'(r_wid - body_c) : 7'd0);
            end
            pif_pkg::S_PAD: if (r_cnt == 7'd0) begin
                n_state = pif_pkg::S_PRE; n_cnt = {5'd0, r_plen};
            end else n_cnt = r_cnt - 7'd1;
            pif_pkg::S_PRE: if (r_cnt == 7'd0) begin
                n_state = pif_pkg::S_ZPAD; n_cnt = (!r_left && r_zpad) ? r_pad : 7'd0;
            end else n_cnt = r_cnt - 7'd1;
            pif_pkg::S_ZPAD: if (r_cnt == 7'd0) begin
                n_state = pif_pkg::S_NZ; n_cnt = r_nz;
            end else n_cnt = r_cnt - 7'd1;
            pif_pkg::S_NZ: if (r_cnt == 7'd0) begin
                n_state = pif_pkg::S_BODY; n_cnt = {2'd0, st.ndig};
            end else n_cnt = r_cnt - 7'd1;
            pif_pkg::S_BODY: if (r_cnt == 7'd0) begin
                n_state = pif_pkg::S_TAIL; n_cnt = r_left ? r_pad : 7'd0;
            end else n_cnt = r_cnt - 7'd1;
            pif_pkg::S_TAIL: if (r_cnt == 7'd0 || r_out == 7'(pif_pkg::MAX_CHARS))
                n_state = pif_pkg::S_IDLE;
                else n_cnt = r_cnt - 7'd1;
            default: n_state = pif_pkg::S_IDLE;
        endcase
        if (r_state != pif_pkg::S_IDLE && r_state != pif_pkg::S_DIGITS &&
            r_out == 7'(pif_pkg::MAX_CHARS)) n_state = pif_pkg::S_IDLE;
    end

    always_comb begin
        emit = 1'b0;
        ch   = pif_pkg::CH_SPACE;
        case (r_state)
            pif_pkg::S_PAD:  begin emit = r_cnt != 7'd0; ch = pif_pkg::CH_SPACE; end
            pif_pkg::S_PRE:  begin
                emit = r_cnt != 7'd0;
                ch = ({5'd0, r_plen} - r_cnt == 7'd0) ? r_pre0 : r_pre1;
            end
            pif_pkg::S_ZPAD: begin emit = r_cnt != 7'd0; ch = pif_pkg::CH_ZERO; end
            pif_pkg::S_NZ:   begin emit = r_cnt != 7'd0; ch = pif_pkg::CH_ZERO; end
            pif_pkg::S_BODY: begin
                emit = r_cnt != 7'd0; ch = pif_pkg::digit_char(rd_digit, r_upper);
            end
            pif_pkg::S_TAIL: begin emit = r_cnt != 7'd0; ch = pif_pkg::CH_SPACE; end
            default: emit = 1'b0;
        endcase
        if (r_out == 7'(pif_pkg::MAX_CHARS)) emit = 1'b0;
        n_out = r_state == pif_pkg::S_DIGITS ? 7'd0 : r_out + {6'd0, emit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pif_pkg::S_IDLE;
            r_cnt   <= 7'd0;
            r_out   <= 7'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_out   <= n_out;
        end
    end

    // hold the last emitted character until the next is known
    logic        r_have;
    logic [7:0]  r_hch;
    logic        finish;
    assign finish = r_state != pif_pkg::S_IDLE && n_state == pif_pkg::S_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have      <= 1'b0;
            o_strobe    <= 1'b0;
        end else begin
            o_strobe    <= (r_have && (emit || finish)) || (finish && !r_have && !emit);
            if (emit) r_have <= 1'b1;
            else if (finish || r_state == pif_pkg::S_DIGITS) r_have <= 1'b0;
        end
        if (emit) r_hch <= ch;
        o_character <= (finish && !r_have && !emit) ? 8'd0 : r_hch;
        o_last      <= finish;
        o_empty_res <= finish && !r_have && !emit;
    end
endmodule
`default_nettype wire

### rtl/pif_checker.sv
// ============================================================================
// pif_checker: port level checks for the integer formatter
// Watches strobe, last, empty and busy framing of each transaction.
// ============================================================================
`default_nettype none
module pif_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic busy,
    input wire logic o_strobe,
    input wire logic o_last,
    input wire logic o_empty_res
);
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_empty_res |-> o_last) else $error("empty without last");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |-> !busy) else $error("busy after last");
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy && !$past(busy) |-> !o_strobe) else $error("strobe while idle");
    a_empty_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_empty_res |-> !$past(o_strobe)) else $error("empty mid text");
endmodule

bind printf_integer_formatter_top pif_checker u_pif_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .busy(busy),
    .o_strobe(o_strobe), .o_last(o_last), .o_empty_res(o_empty_res)
);
`default_nettype wire
